@@ design/ots_pkg.sv @@
// Shared types, constants and command/status records for the ordered key store.
// Used by ots_ctrl, ots_dpath and ordered_tree_key_store; depends on nothing.
package ots_pkg;

  localparam int LOG2_NODES = 6;
  localparam int NODES      = 1 << LOG2_NODES;
  localparam int IDX_W      = LOG2_NODES;
  localparam int LINK_W     = LOG2_NODES + 1;
  localparam int PATH_DEPTH = 13;
  localparam int PIDX_W     = $clog2(PATH_DEPTH);
  localparam int KEY_W      = 32;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam link_t NULL_LINK = link_t'(NODES);

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Tree forms; the top bit of the mode selects red-black
  localparam logic [1:0] MODE_CHAIN = 2'd0;
  localparam logic [1:0] MODE_TREE  = 2'd1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_WALK   = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_INS_SLOT,
    S_UB_RD,
    S_UB_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_RB_RD,
    S_RB_CMP,
    S_RB_SLOT,
    S_FX_TOP,
    S_FX_RC,
    S_FX_RCU,
    S_FX_RG,
    S_FX_RGU,
    S_FX_RN,
    S_FX_RNU,
    S_FX_RL,
    S_FX_RLU,
    S_FX_CF2,
    S_FX_CF3,
    S_FX_ROT1,
    S_FX_ROT2,
    S_FX_NEXT,
    S_WK_DESC,
    S_WK_LEFT,
    S_WK_POP,
    S_WK_POP2,
    S_WK_VISIT,
    S_WK_END
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    idx_t       rd_addr;
    logic       key_we;
    idx_t       key_addr;
    logic       left_we;
    idx_t       left_addr;
    link_t      left_data;
    logic       right_we;
    idx_t       right_addr;
    link_t      right_data;
    logic       red_we;
    idx_t       red_addr;
    logic       red_data;
    logic       stk_we;
    idx_t       stk_addr;
    link_t      stk_data;
    idx_t       stk_rd_addr;
    logic       key_load;
    logic       sum_clr;
    logic       visit;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_found;
    logic       res_prev;
    logic       res_last;
  } ots_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic  less;
    logic  greater;
    link_t left;
    link_t right;
    logic  red;
    link_t stk_q;
    logic  out_free;
  } ots_stat_t;

  function automatic logic is_node(link_t l);
    return ~l[LINK_W-1];
  endfunction

endpackage

@@ design/ordered_tree_key_store.sv @@
// Top level of the ordered key store: APB mode register, controller and datapath.
// Depends on ots_pkg, ots_ctrl and ots_dpath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_stall    | opcode, key
//  result   | out_valid / out_stall  | status, found, key_out, running_sum, last
//  config   | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// One item at a time. A walk is paced by the single read port of the node memory
// and the walk stack. Reset is synchronous and empties the tree; node memories
// need no clearing. A stalled result holds the walk in place; the next item is
// taken while the last result still waits.
module ordered_tree_key_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] key_out,
  output logic signed [31:0] running_sum,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ots_pkg::*;

  logic [1:0] tree_mode;
  ots_cmd_t   cmd;
  ots_stat_t  st;

  // Mode register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_mode <= MODE_TREE;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      tree_mode <= pwdata[1:0];
    end
  end

  assign prdata = (paddr == 3'd0) ? {30'd0, tree_mode} : 32'd0;

  ots_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .tree_mode (tree_mode),
    .cmd       (cmd),
    .st        (st)
  );

  ots_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .key         (key),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .key_out     (key_out),
    .running_sum (running_sum),
    .last        (last)
  );

  // An accepted item keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // An empty walk reports a single zero beat
  a_empty_walk: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> last && key_out == 0 && running_sum == 0)
    else $error("empty walk beat malformed");

  // A hit is a single ok beat
  a_found_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK && last)
    else $error("lookup hit beat malformed");

endmodule

@@ design/ots_ctrl.sv @@
// Controller state machine of the ordered key store: sequences clear, insert, lookup,
// walk and red-black fixups. Depends on ots_pkg; drives ots_dpath by ots_cmd_t.
module ots_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  output logic             in_stall,
  input  logic [1:0]       tree_mode,
  output ots_pkg::ots_cmd_t cmd,
  input  ots_pkg::ots_stat_t st
);
  import ots_pkg::*;

  state_t state, state_next;
  link_t  root, root_next;
  link_t  used, used_next;
  link_t  cur, cur_next;
  link_t  steps, steps_next;
  link_t  sp, sp_next;
  link_t  count, count_next;
  logic   have_prev, have_prev_next;
  logic [PIDX_W-1:0] depth, depth_next;
  logic [PIDX_W-1:0] fi, fi_next;
  logic [PIDX_W-1:0] pidx;
  link_t  cnode, cnode_next;
  link_t  child, child_next;
  link_t  cl, cl_next;
  link_t  crt, crt_next;
  link_t  lf, lf_next;
  logic   tred, tred_next;
  logic   dir, dir_next;
  logic [1:0] res_status, res_status_next;
  logic   res_found, res_found_next;
  logic   path_we;
  link_t  path_node [PATH_DEPTH];
  logic   path_less [PATH_DEPTH];
  link_t  link_sel;
  idx_t   slot;
  logic   rb_mode;

  assign in_stall = (state != S_IDLE);
  assign rb_mode  = tree_mode[1];
  assign slot     = used[IDX_W-1:0];
  assign pidx     = fi - 1'b1;
  assign link_sel = st.less ? st.left : st.right;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      root      <= NULL_LINK;
      used      <= '0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      root      <= root_next;
      used      <= used_next;
      have_prev <= have_prev_next;
    end
  end

  // Working registers and path stack
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    steps      <= steps_next;
    sp         <= sp_next;
    count      <= count_next;
    depth      <= depth_next;
    fi         <= fi_next;
    cnode      <= cnode_next;
    child      <= child_next;
    cl         <= cl_next;
    crt        <= crt_next;
    lf         <= lf_next;
    tred       <= tred_next;
    dir        <= dir_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (path_we) begin
      path_node[depth] <= cur;
      path_less[depth] <= st.less;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    root_next       = root;
    used_next       = used;
    cur_next        = cur;
    steps_next      = steps;
    sp_next         = sp;
    count_next      = count;
    have_prev_next  = have_prev;
    depth_next      = depth;
    fi_next         = fi;
    cnode_next      = cnode;
    child_next      = child;
    cl_next         = cl;
    crt_next        = crt;
    lf_next         = lf;
    tred_next       = tred;
    dir_next        = dir;
    res_status_next = res_status;
    res_found_next  = res_found;
    path_we         = 1'b0;
    cmd             = '0;
    cmd.rd_addr     = cur[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.key_load    = 1'b1;
          cur_next        = root;
          steps_next      = '0;
          depth_next      = '0;
          sp_next         = '0;
          count_next      = '0;
          have_prev_next  = 1'b0;
          res_status_next = ST_OK;
          res_found_next  = 1'b0;
          case (opcode_t'(opcode))
            OP_CLEAR: begin
              root_next  = NULL_LINK;
              used_next  = '0;
              state_next = S_EMIT;
            end
            OP_INSERT: begin
              if (!is_node(used)) begin
                res_status_next = ST_FULL;
                state_next      = S_EMIT;
              end else if (rb_mode) begin
                state_next = S_RB_RD;
              end else begin
                state_next = S_INS_SLOT;
              end
            end
            OP_LOOKUP: state_next = S_LK_RD;
            OP_WALK: begin
              if (!is_node(root)) begin
                res_status_next = ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                cmd.sum_clr = 1'b1;
                state_next  = S_WK_DESC;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // Hand out the next slot for chain and unbalanced modes
      S_INS_SLOT: begin
        cmd.key_we     = 1'b1;
        cmd.key_addr   = slot;
        cmd.left_we    = 1'b1;
        cmd.left_addr  = slot;
        cmd.left_data  = (tree_mode == MODE_CHAIN) ? root : NULL_LINK;
        cmd.right_we   = 1'b1;
        cmd.right_addr = slot;
        cmd.right_data = NULL_LINK;
        cmd.red_we     = 1'b1;
        cmd.red_addr   = slot;
        cmd.red_data   = 1'b1;
        used_next      = used + 1'b1;
        child_next     = used;
        if (tree_mode == MODE_CHAIN || !is_node(root)) begin
          root_next  = used;
          state_next = S_EMIT;
        end else begin
          state_next = S_UB_RD;
        end
      end

      S_UB_RD: state_next = S_UB_CMP;

      // Descend; hang the new slot on the first empty link
      S_UB_CMP: begin
        if (!is_node(link_sel)) begin
          if (st.less) begin
            cmd.left_we   = 1'b1;
            cmd.left_addr = cur[IDX_W-1:0];
            cmd.left_data = child;
          end else begin
            cmd.right_we   = 1'b1;
            cmd.right_addr = cur[IDX_W-1:0];
            cmd.right_data = child;
          end
          state_next = S_EMIT;
        end else begin
          cur_next = link_sel;
          if (steps == link_t'(NODES)) begin
            state_next = S_EMIT;
          end else begin
            steps_next = steps + 1'b1;
            state_next = S_UB_RD;
          end
        end
      end

      S_LK_RD: begin
        if (!is_node(cur)) state_next = S_EMIT;
        else               state_next = S_LK_CMP;
      end

      // Compare; a chain is scanned through its left links
      S_LK_CMP: begin
        if (!st.less && !st.greater) begin
          res_found_next = 1'b1;
          state_next     = S_EMIT;
        end else begin
          if (st.less || tree_mode == MODE_CHAIN) cur_next = st.left;
          else                                    cur_next = st.right;
          if (steps == link_t'(NODES)) begin
            state_next = S_EMIT;
          end else begin
            steps_next = steps + 1'b1;
            state_next = S_LK_RD;
          end
        end
      end

      S_RB_RD: begin
        if (!is_node(cur)) state_next = S_RB_SLOT;
        else               state_next = S_RB_CMP;
      end

      // Record the path; refuse when it would overflow
      S_RB_CMP: begin
        if (depth == PIDX_W'(PATH_DEPTH - 1)) begin
          res_status_next = ST_FULL;
          state_next      = S_EMIT;
        end else begin
          path_we    = 1'b1;
          cur_next   = link_sel;
          depth_next = depth + 1'b1;
          state_next = S_RB_RD;
        end
      end

      S_RB_SLOT: begin
        cmd.key_we     = 1'b1;
        cmd.key_addr   = slot;
        cmd.left_we    = 1'b1;
        cmd.left_addr  = slot;
        cmd.left_data  = NULL_LINK;
        cmd.right_we   = 1'b1;
        cmd.right_addr = slot;
        cmd.right_data = NULL_LINK;
        cmd.red_we     = 1'b1;
        cmd.red_addr   = slot;
        cmd.red_data   = 1'b1;
        used_next      = used + 1'b1;
        child_next     = used;
        fi_next        = depth;
        state_next     = S_FX_TOP;
      end

      // Relink one level on the way up, or finish at the root
      S_FX_TOP: begin
        if (fi == '0) begin
          root_next = child;
          if (is_node(child)) begin
            cmd.red_we   = 1'b1;
            cmd.red_addr = child[IDX_W-1:0];
            cmd.red_data = 1'b0;
          end
          state_next = S_EMIT;
        end else if (!is_node(path_node[pidx])) begin
          state_next = S_EMIT;
        end else begin
          cnode_next = path_node[pidx];
          dir_next   = path_less[pidx];
          if (path_less[pidx]) begin
            cmd.left_we   = 1'b1;
            cmd.left_addr = path_node[pidx][IDX_W-1:0];
            cmd.left_data = child;
          end else begin
            cmd.right_we   = 1'b1;
            cmd.right_addr = path_node[pidx][IDX_W-1:0];
            cmd.right_data = child;
          end
          state_next = S_FX_RC;
        end
      end

      S_FX_RC: begin
        cmd.rd_addr = child[IDX_W-1:0];
        if (!is_node(child)) state_next = S_EMIT;
        else                 state_next = S_FX_RCU;
      end

      S_FX_RCU: begin
        cmd.rd_addr = child[IDX_W-1:0];
        cl_next     = st.left;
        crt_next    = st.right;
        if (!st.red)           state_next = S_EMIT;
        else if (!dir)         state_next = S_FX_RN;
        else if (is_node(st.left)) state_next = S_FX_RG;
        else                   state_next = S_FX_NEXT;
      end

      S_FX_RG: begin
        cmd.rd_addr = cl[IDX_W-1:0];
        state_next  = S_FX_RGU;
      end

      // Two reds on the left: rotate right
      S_FX_RGU: begin
        cmd.rd_addr = cl[IDX_W-1:0];
        if (st.red) begin
          cmd.red_we     = 1'b1;
          cmd.red_addr   = cl[IDX_W-1:0];
          cmd.red_data   = 1'b0;
          cmd.left_we    = 1'b1;
          cmd.left_addr  = cnode[IDX_W-1:0];
          cmd.left_data  = crt;
          cmd.right_we   = 1'b1;
          cmd.right_addr = child[IDX_W-1:0];
          cmd.right_data = cnode;
          cnode_next     = child;
        end
        state_next = S_FX_NEXT;
      end

      S_FX_RN: begin
        cmd.rd_addr = cnode[IDX_W-1:0];
        state_next  = S_FX_RNU;
      end

      S_FX_RNU: begin
        cmd.rd_addr = cnode[IDX_W-1:0];
        lf_next     = st.left;
        tred_next   = st.red;
        if (is_node(st.left)) state_next = S_FX_RL;
        else                  state_next = S_FX_ROT1;
      end

      S_FX_RL: begin
        cmd.rd_addr = lf[IDX_W-1:0];
        state_next  = S_FX_RLU;
      end

      // Both children red: flip colors, else rotate left
      S_FX_RLU: begin
        cmd.rd_addr = lf[IDX_W-1:0];
        if (st.red) begin
          cmd.red_we   = 1'b1;
          cmd.red_addr = lf[IDX_W-1:0];
          cmd.red_data = 1'b0;
          state_next   = S_FX_CF2;
        end else begin
          state_next = S_FX_ROT1;
        end
      end

      S_FX_CF2: begin
        cmd.red_we   = 1'b1;
        cmd.red_addr = child[IDX_W-1:0];
        cmd.red_data = 1'b0;
        state_next   = S_FX_CF3;
      end

      S_FX_CF3: begin
        cmd.red_we   = 1'b1;
        cmd.red_addr = cnode[IDX_W-1:0];
        cmd.red_data = 1'b1;
        state_next   = S_FX_NEXT;
      end

      S_FX_ROT1: begin
        cmd.right_we   = 1'b1;
        cmd.right_addr = cnode[IDX_W-1:0];
        cmd.right_data = cl;
        cmd.left_we    = 1'b1;
        cmd.left_addr  = child[IDX_W-1:0];
        cmd.left_data  = cnode;
        cmd.red_we     = 1'b1;
        cmd.red_addr   = child[IDX_W-1:0];
        cmd.red_data   = tred;
        state_next     = S_FX_ROT2;
      end

      S_FX_ROT2: begin
        cmd.red_we   = 1'b1;
        cmd.red_addr = cnode[IDX_W-1:0];
        cmd.red_data = 1'b1;
        cnode_next   = child;
        state_next   = S_FX_NEXT;
      end

      S_FX_NEXT: begin
        child_next = cnode;
        fi_next    = pidx;
        state_next = S_FX_TOP;
      end

      // Push left spine onto the walk stack
      S_WK_DESC: begin
        if (is_node(cur) && is_node(sp)) begin
          cmd.stk_we   = 1'b1;
          cmd.stk_addr = sp[IDX_W-1:0];
          cmd.stk_data = cur;
          sp_next      = sp + 1'b1;
          state_next   = S_WK_LEFT;
        end else begin
          state_next = S_WK_POP;
        end
      end

      S_WK_LEFT: begin
        cur_next   = st.left;
        state_next = S_WK_DESC;
      end

      S_WK_POP: begin
        if (sp == '0) begin
          state_next = S_WK_END;
        end else begin
          cmd.stk_rd_addr = idx_t'(sp - 1'b1);
          sp_next         = sp - 1'b1;
          state_next      = S_WK_POP2;
        end
      end

      S_WK_POP2: begin
        cur_next    = st.stk_q;
        cmd.rd_addr = st.stk_q[IDX_W-1:0];
        state_next  = S_WK_VISIT;
      end

      // Send the previous key on, hold this one until the next is known
      S_WK_VISIT: begin
        if (!have_prev || st.out_free) begin
          cmd.res_load   = have_prev;
          cmd.res_status = ST_OK;
          cmd.res_prev   = 1'b1;
          cmd.visit      = 1'b1;
          have_prev_next = 1'b1;
          cur_next       = st.right;
          count_next     = count + 1'b1;
          if (count == link_t'(NODES - 1)) state_next = S_WK_END;
          else                             state_next = S_WK_DESC;
        end
      end

      S_WK_END: begin
        if (st.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_prev   = 1'b1;
          cmd.res_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (st.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = res_status;
          cmd.res_found  = res_found;
          cmd.res_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/ots_dpath.sv @@
// Datapath of the ordered key store: node memories, walk stack, key compare,
// running sum and the result register. Depends on ots_pkg; driven by ots_ctrl.
module ots_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [31:0]      key,
  input  ots_pkg::ots_cmd_t       cmd,
  output ots_pkg::ots_stat_t      st,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic                    found,
  output logic signed [31:0]      key_out,
  output logic signed [31:0]      running_sum,
  output logic                    last
);
  import ots_pkg::*;

  logic [KEY_W-1:0] key_mem   [NODES];
  link_t            left_mem  [NODES];
  link_t            right_mem [NODES];
  logic             red_mem   [NODES];
  link_t            stk_mem   [NODES];

  logic signed [KEY_W-1:0] key_reg;
  logic signed [KEY_W-1:0] rd_key;
  link_t                   rd_left;
  link_t                   rd_right;
  logic                    rd_red;
  link_t                   stk_q;
  logic signed [KEY_W-1:0] sum;
  logic signed [KEY_W-1:0] sum_next;
  logic signed [KEY_W-1:0] prev_key;
  logic signed [KEY_W-1:0] prev_sum;
  logic                    out_free;

  // Node memory writes
  always_ff @(posedge clk) begin
    if (cmd.key_we)   key_mem[cmd.key_addr]     <= key_reg;
    if (cmd.left_we)  left_mem[cmd.left_addr]   <= cmd.left_data;
    if (cmd.right_we) right_mem[cmd.right_addr] <= cmd.right_data;
    if (cmd.red_we)   red_mem[cmd.red_addr]     <= cmd.red_data;
  end

  // Registered node read, all fields at one slot
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[cmd.rd_addr];
    rd_left  <= left_mem[cmd.rd_addr];
    rd_right <= right_mem[cmd.rd_addr];
    rd_red   <= red_mem[cmd.rd_addr];
  end

  // Walk stack
  always_ff @(posedge clk) begin
    if (cmd.stk_we) stk_mem[cmd.stk_addr] <= cmd.stk_data;
    stk_q <= stk_mem[cmd.stk_rd_addr];
  end

  // Key, running sum and held walk result
  assign sum_next = sum + rd_key;

  always_ff @(posedge clk) begin
    if (cmd.key_load) key_reg <= key;
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.visit) begin
      sum      <= sum_next;
      prev_key <= rd_key;
      prev_sum <= sum_next;
    end
  end

  // Result register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status      <= cmd.res_status;
      found       <= cmd.res_found;
      key_out     <= cmd.res_found ? key_reg : (cmd.res_prev ? prev_key : '0);
      running_sum <= cmd.res_prev ? prev_sum : '0;
      last        <= cmd.res_last;
    end
  end

  assign st.less     = key_reg < rd_key;
  assign st.greater  = rd_key < key_reg;
  assign st.left     = rd_left;
  assign st.right    = rd_right;
  assign st.red      = rd_red;
  assign st.stk_q    = stk_q;
  assign st.out_free = out_free;

endmodule

@@ sim/key_store_checker.sv @@
// Result checker for the ordered key store: mirrors the tree in behavioral form,
// predicts each item's results and compares every accepted result beat. Depends on ots_pkg.
module key_store_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] key,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic               found,
  input  logic signed [31:0] key_out,
  input  logic signed [31:0] running_sum,
  input  logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ots_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic        fnd;
    logic [31:0] k;
    logic [31:0] sum;
    logic        lst;
  } result_t;

  result_t     result_q[$];
  logic [1:0]  mode;
  logic [31:0] mkeys[NODES];
  link_t       mleft[NODES];
  link_t       mright[NODES];
  logic        mred[NODES];
  link_t       mroot;
  int unsigned mused;

  function automatic bit node_ok(link_t n);
    return n < NODES;
  endfunction

  function automatic bit red_at(link_t n);
    return node_ok(n) ? mred[n] : 1'b0;
  endfunction

  function automatic link_t left_at(link_t n);
    return node_ok(n) ? mleft[n] : NULL_LINK;
  endfunction

  function automatic link_t right_at(link_t n);
    return node_ok(n) ? mright[n] : NULL_LINK;
  endfunction

  function automatic void new_node(link_t s, logic [31:0] k);
    mkeys[s] = k; mleft[s] = NULL_LINK; mright[s] = NULL_LINK; mred[s] = 1'b1;
    mused = s + 1;
  endfunction

  // Red-black descent and fix-up; returns 0 when the path would overflow.
  function automatic bit rb_insert(logic [31:0] k);
    link_t pnode[PATH_DEPTH];
    bit    pless[PATH_DEPTH];
    int    d;
    link_t c, ch, t, g;
    bit    tred;
    d = 0;
    pnode[0] = mroot;
    while (node_ok(pnode[d])) begin
      c = pnode[d];
      if (d + 1 >= PATH_DEPTH) return 0;
      pless[d] = $signed(k) < $signed(mkeys[c]);
      pnode[d+1] = pless[d] ? mleft[c] : mright[c];
      d++;
    end
    new_node(link_t'(mused), k);
    pnode[d] = link_t'(mused - 1);
    for (int i = d - 1; i >= 0; i--) begin
      c = pnode[i];
      ch = pnode[i+1];
      if (!node_ok(c)) return 1;
      if (pless[i]) begin
        mleft[c] = ch;
        if (!red_at(ch)) return 1;
        g = left_at(ch);
        if (node_ok(g) && mred[g]) begin
          mred[g] = 1'b0;
          t = mleft[c];
          mleft[c] = right_at(t);
          if (node_ok(t)) mright[t] = c;
          c = t;
        end
      end else begin
        mright[c] = ch;
        if (!red_at(ch)) return 1;
        g = mleft[c];
        if (node_ok(g) && mred[g]) begin
          mred[g] = 1'b0;
          if (node_ok(ch)) mred[ch] = 1'b0;
          mred[c] = 1'b1;
        end else begin
          tred = mred[c];
          t = mright[c];
          mright[c] = left_at(t);
          if (node_ok(t)) begin
            mleft[t] = c;
            mred[t] = tred;
          end
          mred[c] = 1'b1;
          c = t;
        end
      end
      pnode[i] = c;
    end
    mroot = pnode[0];
    if (node_ok(mroot)) mred[mroot] = 1'b0;
    return 1;
  endfunction

  function automatic logic [1:0] insert_key(logic [31:0] k);
    link_t s, c;
    s = link_t'(mused);
    if (mused >= NODES) return ST_FULL;
    if (mode[1]) return rb_insert(k) ? ST_OK : ST_FULL;
    new_node(s, k);
    if (mode == MODE_CHAIN) begin
      mleft[s] = mroot;
      mroot = s;
    end else if (!node_ok(mroot)) begin
      mroot = s;
    end else begin
      c = mroot;
      for (int n = 0; n <= NODES; n++) begin
        if ($signed(k) < $signed(mkeys[c])) begin
          if (!node_ok(mleft[c])) begin mleft[c] = s; break; end
          c = mleft[c];
        end else begin
          if (!node_ok(mright[c])) begin mright[c] = s; break; end
          c = mright[c];
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic bit lookup_key(logic [31:0] k);
    link_t c;
    c = mroot;
    for (int n = 0; n <= NODES && node_ok(c); n++) begin
      if ($signed(k) < $signed(mkeys[c])) c = mleft[c];
      else if ($signed(k) > $signed(mkeys[c]))
        c = (mode == MODE_CHAIN) ? mleft[c] : mright[c];
      else return 1;
    end
    return 0;
  endfunction

  function automatic void walk_keys();
    link_t       stk[$];
    link_t       c;
    logic [31:0] sum;
    int          cnt;
    result_t     r;
    c = mroot; sum = '0; cnt = 0;
    if (!node_ok(c)) begin
      result_q.push_back('{ST_EMPTY, 1'b0, 32'd0, 32'd0, 1'b1});
      return;
    end
    while (cnt < NODES) begin
      while (node_ok(c) && stk.size() < NODES) begin
        stk.push_back(c);
        c = mleft[c];
      end
      if (stk.size() == 0) break;
      c = stk.pop_back();
      sum += mkeys[c];
      result_q.push_back('{ST_OK, 1'b0, mkeys[c], sum, 1'b0});
      cnt++;
      c = mright[c];
    end
    r = result_q.pop_back();
    r.lst = 1'b1;
    result_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on accepted input beats and config writes, compare result beats.
  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      mode <= MODE_TREE;
      mroot = NULL_LINK;
      mused = 0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) mode <= pwdata[1:0];
      if (in_valid && !in_stall) begin
        case (opcode_t'(opcode))
          OP_CLEAR: begin
            mroot = NULL_LINK;
            mused = 0;
            result_q.push_back('{ST_OK, 1'b0, 32'd0, 32'd0, 1'b1});
          end
          OP_INSERT: result_q.push_back('{insert_key(key), 1'b0, 32'd0, 32'd0, 1'b1});
          OP_LOOKUP: begin
            if (lookup_key(key)) result_q.push_back('{ST_OK, 1'b1, key, 32'd0, 1'b1});
            else result_q.push_back('{ST_OK, 1'b0, 32'd0, 32'd0, 1'b1});
          end
          default: walk_keys();
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", 32'd1, 32'd0);
        end else begin
          w = result_q.pop_front();
          if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
          if (found !== w.fnd) report_mismatch("found", 32'(found), 32'(w.fnd));
          if (key_out !== w.k) report_mismatch("key_out", key_out, w.k);
          if (running_sum !== w.sum) report_mismatch("running_sum", running_sum, w.sum);
          if (last !== w.lst) report_mismatch("last", 32'(last), 32'(w.lst));
        end
      end
    end
    pending = result_q.size();
  end
endmodule

@@ sim/testbench.sv @@
// Top of the key store bench: clock, reset, APB mode writes, item stimulus and verdict.
// Depends on ots_pkg, ordered_tree_key_store and key_store_checker.
module testbench;
  import ots_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 40000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_CLEAR;
  logic signed [31:0] key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] key_out;
  logic signed [31:0] running_sum;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  bit                 quiet_sink = 1'b0;
  bit                 hold_sink = 1'b0;
  int                 idle_cycles = 0;
  logic [31:0]        used_keys[$];

  ordered_tree_key_store DUT (.*);

  key_store_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts, or for one long hold.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_sink = 1'b0;
      end else if (!quiet_sink && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one beat; valid stays high into the next beat unless a gap is taken.
  task automatic send_item(opcode_t op, logic [31:0] k, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1; opcode <= op; key <= k;
    do @(posedge clk); while (in_stall);
    if (op == OP_INSERT) used_keys.push_back(k);
    if (op == OP_CLEAR) used_keys.delete();
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return (used_keys.size() != 0) ? used_keys[$urandom_range(0, used_keys.size() - 1)]
                                         : $urandom();
      3: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count, int ins_weight, bit gaps);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(OP_CLEAR, $urandom(), gaps);
      else if (r < ins_weight) send_item(OP_INSERT, pick_key(), gaps);
      else if (r < 90) send_item(OP_LOOKUP, pick_key(), gaps);
      else send_item(OP_WALK, $urandom(), gaps);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty walk, extremes, duplicates, lookups and full store.
    send_item(OP_WALK, 32'd0, 0);
    send_item(OP_INSERT, 32'h7fff_ffff, 0);
    send_item(OP_INSERT, 32'h8000_0000, 0);
    send_item(OP_INSERT, 32'd5, 0);
    send_item(OP_INSERT, 32'd5, 0);
    send_item(OP_INSERT, 32'hffff_ffff, 0);
    send_item(OP_LOOKUP, 32'd5, 0);
    send_item(OP_LOOKUP, 32'd6, 0);
    send_item(OP_LOOKUP, 32'h8000_0000, 0);
    send_item(OP_WALK, 32'd0, 0);
    drain();
    write_mode(MODE_CHAIN);
    send_item(OP_LOOKUP, 32'h7fff_ffff, 0);
    send_item(OP_LOOKUP, 32'd3, 0);
    send_item(OP_WALK, 32'd0, 0);
    drain();
    // Descending inserts in mode 1 build a deep chain; a red-black insert into it then overflows the path.
    write_mode(MODE_TREE);
    send_item(OP_CLEAR, 32'd0, 0);
    for (int i = 0; i < 14; i++) send_item(OP_INSERT, 32'(100 - i), 0);
    drain();
    write_mode(2'd2);
    send_item(OP_INSERT, 32'd1, 0);
    send_item(OP_INSERT, 32'd500, 0);
    drain();
    write_mode(2'd3);
    send_item(OP_CLEAR, 32'd0, 0);
    for (int i = 0; i < 65; i++) send_item(OP_INSERT, $urandom(), 1);
    send_item(OP_WALK, 32'd0, 0);
    // Hold the result side for a long stretch while items keep coming.
    hold_sink = 1'b1;
    send_item(OP_WALK, 32'd0, 0);
    send_item(OP_LOOKUP, pick_key(), 0);
    send_item(OP_CLEAR, 32'd0, 0);
    drain();

    // Random phases through every mode, clearing first each time.
    for (int m = 0; m < 4; m++) begin
      write_mode(m[1:0]);
      send_item(OP_CLEAR, 32'd0, 1);
      random_phase(4, 60, 1);
      drain();
    end
    write_mode(2'd2);
    quiet_sink = 1'b1;
    random_phase(6, 60, 0);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
